/* rtl/pbeq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the push button event qualifier.
package pbeq_pkg;

	// Width of the timestamp field and of each threshold register.
	localparam int TS_W = 32;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;

	// Default elapsed-time arithmetic width.
	localparam int TIME_BITS_DEF = 32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_LONG_RELEASE = 3'd1,
		REG_LONG_PUSH = 3'd2,
		REG_IDLE_TIMEOUT = 3'd3,
		REG_ACTIVE_LOW = 3'd4
	} cfg_reg_t;

	// Configuration reset values.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 32'd10000;
	localparam logic [CFG_W-1:0] LONG_RELEASE_RST = 32'd1000000;
	localparam logic [CFG_W-1:0] LONG_PUSH_RST = 32'd1000000;
	localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 32'd5000000;
	localparam logic ACTIVE_LOW_RST = 1'b1;

	// Request source codes.
	localparam logic FUNC_POLL = 1'b0;
	localparam logic FUNC_EDGE = 1'b1;

	// Event codes reported with each result.
	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_PUSH = 3'd1,
		EV_LONG_PUSH = 3'd2,
		EV_SHORT_REL = 3'd3,
		EV_LONG_REL = 3'd4,
		EV_TIMEOUT = 3'd5
	} event_t;

	// Button status codes as reported on the result channel.
	localparam logic [1:0] BS_IDLE = 2'd0;
	localparam logic [1:0] BS_ACTIVE = 2'd1;
	localparam logic [1:0] BS_REL_PEND = 2'd2;
	localparam logic [1:0] BS_TO_PEND = 2'd3;

	// Internal one-hot status.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACTIVE = 4'b0010,
		ST_REL_PEND = 4'b0100,
		ST_TO_PEND = 4'b1000
	} status_t;

	// Input request payload.
	typedef struct packed {
		logic func;
		logic [TS_W-1:0] event_time_us;
		logic pin_level;
		logic edge_rise;
		logic edge_fall;
	} in_req_t;

	// Result payload.
	typedef struct packed {
		logic [2:0] event_code;
		logic [1:0] button_state;
	} out_res_t;

	// Map the one-hot status onto its reported code.
	function automatic logic [1:0] status_code(input status_t st);
		logic [1:0] code;
		case (st)
			ST_IDLE: code = BS_IDLE;
			ST_ACTIVE: code = BS_ACTIVE;
			ST_REL_PEND: code = BS_REL_PEND;
			ST_TO_PEND: code = BS_TO_PEND;
			default: code = BS_IDLE;
		endcase
		return code;
	endfunction

endpackage

/* rtl/push_button_event_qualifier_core.sv */
`timescale 1ns / 1ps
// Push button event qualifier: input register, event logic and result register.
//
// Usage:
// Each request on the input channel (in_valid, in_stall, in_data) carries a
// microsecond timestamp and either a polled pin level or an edge mask. The
// block returns exactly one result per request on the output channel
// (out_valid, out_stall, out_data): an event code and the button status after
// that request. Thresholds and pin polarity are set through the write port
// (cfg_we, cfg_index, cfg_wdata); the user must write them only while no
// request is in flight, which the block itself does not enforce. An accepted
// request moves on to the result register once that one is free or drains.
// Throughput: one request per cycle while the receiver does not stall; the event
// logic is one subtract and a few compares between input and result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; in_stall rises only once both are full.
// Reset clears both stages, sets the status to idle, the last pushed level
// to released, the last change time to zero and the registers to defaults.
module push_button_event_qualifier_core #(
	parameter int TIME_BITS = pbeq_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input pbeq_pkg::in_req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output pbeq_pkg::out_res_t out_data,
	input logic cfg_we,
	input logic [pbeq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pbeq_pkg::CFG_W-1:0] cfg_wdata
);
	import pbeq_pkg::*;

	// Compare width: elapsed time and registers both at full value.
	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	// Configuration registers.
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_release_q;
	logic [CFG_W-1:0] long_push_q;
	logic [CFG_W-1:0] idle_timeout_q;
	logic active_low_q;

	// Button state.
	status_t status_q;
	logic last_pushed_q;
	logic [TIME_BITS-1:0] last_change_q;

	// Pipeline stages.
	logic req_valid_s1;
	in_req_t req_s1;
	logic out_valid_s2;
	out_res_t res_s2;

	// Event logic signals.
	logic adv_s1;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic [CMP_W-1:0] elapsed_c;
	logic lt_debounce;
	logic le_debounce;
	logic lt_long_release;
	logic ge_long_push;
	logic ge_idle_timeout;
	logic poll_pushed;
	logic edge_pushed;
	event_t release_ev;
	event_t ev_c;
	status_t status_c;
	logic last_pushed_c;
	logic [TIME_BITS-1:0] last_change_c;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_release_q <= LONG_RELEASE_RST;
			long_push_q <= LONG_PUSH_RST;
			idle_timeout_q <= IDLE_TIMEOUT_RST;
			active_low_q <= ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_wdata;
				REG_LONG_RELEASE: long_release_q <= cfg_wdata;
				REG_LONG_PUSH: long_push_q <= cfg_wdata;
				REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata;
				REG_ACTIVE_LOW: active_low_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on when the result register is free or drains.
	assign adv_s1 = !out_valid_s2 || !out_stall;
	assign in_stall = req_valid_s1 && !adv_s1;
	assign out_valid = out_valid_s2;
	assign out_data = res_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			req_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	// Elapsed time and threshold compares.
	always_comb begin
		now_t = TIME_BITS'(req_s1.event_time_us);
		elapsed = now_t - last_change_q;
		elapsed_c = CMP_W'(elapsed);
		lt_debounce = elapsed_c < CMP_W'(debounce_q);
		le_debounce = elapsed_c <= CMP_W'(debounce_q);
		lt_long_release = elapsed_c < CMP_W'(long_release_q);
		ge_long_push = elapsed_c >= CMP_W'(long_push_q);
		ge_idle_timeout = elapsed_c >= CMP_W'(idle_timeout_q);
		poll_pushed = req_s1.pin_level ^ active_low_q;
		edge_pushed = active_low_q ? (req_s1.edge_fall && !req_s1.edge_rise)
			: (req_s1.edge_rise && !req_s1.edge_fall);
		release_ev = lt_long_release ? EV_SHORT_REL : EV_LONG_REL;
	end

	// Event decision and next state.
	always_comb begin
		ev_c = EV_NONE;
		status_c = status_q;
		last_pushed_c = last_pushed_q;
		last_change_c = last_change_q;
		if (req_s1.func == FUNC_EDGE) begin
			// Edge events always record the timestamp.
			last_change_c = now_t;
			if (!le_debounce) begin
				if (edge_pushed) begin
					ev_c = EV_PUSH;
					status_c = ST_ACTIVE;
				end else begin
					ev_c = release_ev;
					status_c = ST_TO_PEND;
				end
			end
		end else if (poll_pushed == last_pushed_q) begin
			// Steady level: check the long push and time-out windows.
			if (status_q == ST_ACTIVE && ge_long_push) begin
				ev_c = EV_LONG_PUSH;
				status_c = ST_REL_PEND;
			end else if (status_q == ST_TO_PEND && ge_idle_timeout) begin
				ev_c = EV_TIMEOUT;
				status_c = ST_IDLE;
			end
		end else if (!lt_debounce) begin
			// Debounced level change.
			last_pushed_c = poll_pushed;
			last_change_c = now_t;
			if (poll_pushed) begin
				ev_c = EV_PUSH;
				status_c = ST_ACTIVE;
			end else begin
				ev_c = release_ev;
				status_c = ST_TO_PEND;
			end
		end
	end

	// State and result register update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_IDLE;
			last_pushed_q <= 1'b0;
			last_change_q <= '0;
			out_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			out_valid_s2 <= req_valid_s1;
			if (req_valid_s1) begin
				status_q <= status_c;
				last_pushed_q <= last_pushed_c;
				last_change_q <= last_change_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid_s1) begin
			res_s2.event_code <= ev_c;
			res_s2.button_state <= status_code(status_c);
		end
	end

	// Checks on the event logic and the stage handoff.
	a_push_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_code == EV_PUSH |-> out_data.button_state == BS_ACTIVE)
		else $error("push result without active status");

	a_long_push_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_code == EV_LONG_PUSH
		|-> out_data.button_state == BS_REL_PEND)
		else $error("long push result without release pending status");

	a_release_to_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid
		&& (out_data.event_code == EV_SHORT_REL || out_data.event_code == EV_LONG_REL)
		|-> out_data.button_state == BS_TO_PEND)
		else $error("release result without time-out pending status");

	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_code == EV_TIMEOUT |-> out_data.button_state == BS_IDLE)
		else $error("time-out result without idle status");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> req_valid_s1 && out_valid_s2)
		else $error("input stalled while a stage is free");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && adv_s1 |=> out_valid_s2)
		else $error("request lost between input and result stage");

endmodule

/* bench/push_button_event_qualifier_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the push button event qualifier core, with its own event predictor.
module push_button_event_qualifier_core_test;
	import pbeq_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	// Tracks the button the way the block should and holds the events still owed by it.
	class button_event_scoreboard;
		logic [CFG_W-1:0] debounce_us;
		logic [CFG_W-1:0] long_release_us;
		logic [CFG_W-1:0] long_push_us;
		logic [CFG_W-1:0] idle_timeout_us;
		logic act_low;
		logic [1:0] status;
		logic last_pushed;
		logic [TS_W-1:0] last_change_us;
		out_res_t expected_events[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned event_count[6];

		function new();
			debounce_us = DEBOUNCE_RST;
			long_release_us = LONG_RELEASE_RST;
			long_push_us = LONG_PUSH_RST;
			idle_timeout_us = IDLE_TIMEOUT_RST;
			act_low = ACTIVE_LOW_RST;
			status = BS_IDLE;
			last_pushed = 1'b0;
			last_change_us = '0;
			mismatches = 0;
			checked = 0;
			foreach (event_count[i]) event_count[i] = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_DEBOUNCE: debounce_us = value;
				REG_LONG_RELEASE: long_release_us = value;
				REG_LONG_PUSH: long_push_us = value;
				REG_IDLE_TIMEOUT: idle_timeout_us = value;
				REG_ACTIVE_LOW: act_low = value[0];
				default: ;
			endcase
		endfunction

		// Advances the button state by one request and returns the event it raises.
		function event_t qualify(in_req_t req);
			logic [TS_W-1:0] elapsed;
			logic pushed;
			event_t ev;
			elapsed = req.event_time_us - last_change_us;
			ev = EV_NONE;
			if (req.func == FUNC_EDGE) begin
				// Only a lone edge in the pushing direction is a push; anything else releases.
				if (act_low)
					pushed = req.edge_fall && !req.edge_rise;
				else
					pushed = req.edge_rise && !req.edge_fall;
				last_change_us = req.event_time_us;
				if (elapsed > debounce_us) begin
					if (pushed) begin
						status = BS_ACTIVE;
						ev = EV_PUSH;
					end else begin
						status = BS_TO_PEND;
						ev = (elapsed < long_release_us) ? EV_SHORT_REL : EV_LONG_REL;
					end
				end
			end else begin
				pushed = req.pin_level ^ act_low;
				if (pushed == last_pushed) begin
					// Steady level: only the long push and the idle time-out can fire.
					if (status == BS_ACTIVE && elapsed >= long_push_us) begin
						status = BS_REL_PEND;
						ev = EV_LONG_PUSH;
					end else if (status == BS_TO_PEND && elapsed >= idle_timeout_us) begin
						status = BS_IDLE;
						ev = EV_TIMEOUT;
					end
				end else if (elapsed >= debounce_us) begin
					last_pushed = pushed;
					last_change_us = req.event_time_us;
					if (pushed) begin
						status = BS_ACTIVE;
						ev = EV_PUSH;
					end else begin
						status = BS_TO_PEND;
						ev = (elapsed < long_release_us) ? EV_SHORT_REL : EV_LONG_REL;
					end
				end
			end
			return ev;
		endfunction

		function void note_request(in_req_t req);
			event_t ev;
			out_res_t want;
			ev = qualify(req);
			event_count[int'(ev)]++;
			want.event_code = ev;
			want.button_state = status;
			expected_events.push_back(want);
		endfunction

		function void check_result(out_res_t got);
			out_res_t want;
			if (expected_events.size() == 0) begin
				$error("result with no request outstanding: event_code %0d button_state %0d",
					got.event_code, got.button_state);
				mismatches++;
				return;
			end
			want = expected_events.pop_front();
			checked++;
			if (got.event_code !== want.event_code) begin
				$error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
				mismatches++;
			end
			if (got.button_state !== want.button_state) begin
				$error("button_state: expected %0d, got %0d", want.button_state,
					got.button_state);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_res_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	button_event_scoreboard sb;
	int unsigned gap_max = 16;
	int unsigned stall_max = 16;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	logic [TS_W-1:0] now_us = '0;

	push_button_event_qualifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Requests and results are taken as they cross each channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(in_data);
			if (out_valid === 1'b1 && !out_stall)
				sb.check_result(out_data);
		end
	end

	// Ends the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver holds off each result for a random number of cycles.
	initial begin
		int unsigned hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = $urandom_range(0, stall_max);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Offers one request after a random gap and holds it until it is taken.
	task automatic send(logic func, logic [TS_W-1:0] stamp, logic pin, logic rise, logic fall);
		int unsigned gap;
		in_req_t req;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.func = func;
		req.event_time_us = stamp;
		req.pin_level = pin;
		req.edge_rise = rise;
		req.edge_fall = fall;
		in_data <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
	endtask

	task automatic send_poll(logic pressed, int unsigned step);
		now_us += $urandom_range(0, step);
		send(FUNC_POLL, now_us, pressed ^ sb.act_low, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// A press is a lone edge in the pushing direction; a release is any other mask.
	task automatic send_mask(logic pressed, int unsigned step);
		logic rise;
		logic fall;
		now_us += $urandom_range(0, step);
		if (pressed) begin
			rise = !sb.act_low;
			fall = sb.act_low;
		end else begin
			case ($urandom_range(0, 2))
				0: begin rise = sb.act_low; fall = !sb.act_low; end
				1: begin rise = 1'b1; fall = 1'b1; end
				default: begin rise = 1'b0; fall = 1'b0; end
			endcase
		end
		send(FUNC_EDGE, now_us, 1'($urandom_range(0, 1)), rise, fall);
	endtask

	// A bouncy press, a hold, a bouncy release and some quiet samples afterwards.
	task automatic press_episode(int unsigned step);
		int unsigned n;
		n = $urandom_range(0, 3);
		repeat (n) send_poll(1'($urandom_range(0, 1)), step / 8);
		if ($urandom_range(0, 3) == 0)
			send_mask(1'b1, step);
		else
			send_poll(1'b1, step);
		n = $urandom_range(0, 4);
		repeat (n) send_poll(1'b1, step);
		n = $urandom_range(0, 3);
		repeat (n) send_poll(1'($urandom_range(0, 1)), step / 8);
		if ($urandom_range(0, 3) == 0)
			send_mask(1'b0, step);
		else
			send_poll(1'b0, step);
		n = $urandom_range(0, 3);
		repeat (n) send_poll(1'b0, 2 * step);
	endtask

	task automatic noise_item(int unsigned step);
		if ($urandom_range(0, 3) == 0)
			now_us = $urandom();
		else
			now_us += $urandom_range(0, step);
		send(1'($urandom_range(0, 1)), now_us, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic run_random(int unsigned count, int unsigned step);
		int unsigned stop;
		stop = items_sent + count;
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) < 7)
				press_episode(step);
			else
				noise_item(step);
		end
	endtask

	// Lets every outstanding result come back before the registers change.
	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_thresholds(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lrel,
			logic [CFG_W-1:0] lpush, logic [CFG_W-1:0] idle, logic al);
		write_cfg(REG_DEBOUNCE, deb);
		write_cfg(REG_LONG_RELEASE, lrel);
		write_cfg(REG_LONG_PUSH, lpush);
		write_cfg(REG_IDLE_TIMEOUT, idle);
		write_cfg(REG_ACTIVE_LOW, {{(CFG_W-1){1'b0}}, al});
	endtask

	task automatic run_phase(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lrel,
			logic [CFG_W-1:0] lpush, logic [CFG_W-1:0] idle, logic al,
			int unsigned step, int unsigned count, int unsigned gmax, int unsigned smax);
		program_thresholds(deb, lrel, lpush, idle, al);
		gap_max = gmax;
		stall_max = smax;
		run_random(count, step);
		finish_phase();
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: debounce boundary, long push, release pending, long release, time-out.
		send(FUNC_POLL, 32'd0, 1'b1, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd5000, 1'b0, 1'b1, 1'b1);
		send(FUNC_POLL, 32'd10000, 1'b0, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd1010000, 1'b0, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd1010001, 1'b0, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd1020001, 1'b1, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd6020000, 1'b1, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd6020001, 1'b1, 1'b0, 1'b0);
		// Edge masks: inclusive debounce, push, both edges, no edge, wrong-direction edge.
		send(FUNC_EDGE, 32'd6030001, 1'b1, 1'b0, 1'b1);
		send(FUNC_EDGE, 32'd6040002, 1'b0, 1'b0, 1'b1);
		send(FUNC_EDGE, 32'd6050003, 1'b1, 1'b1, 1'b1);
		send(FUNC_EDGE, 32'd7100000, 1'b0, 1'b0, 1'b0);
		send(FUNC_EDGE, 32'd7200000, 1'b0, 1'b1, 1'b0);
		// Elapsed time across the timestamp wrap.
		send(FUNC_POLL, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
		send(FUNC_POLL, 32'd999998, 1'b0, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd999999, 1'b0, 1'b0, 1'b0);
		finish_phase();

		// Extreme thresholds with the pin active high.
		program_thresholds(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
		send(FUNC_POLL, 32'd1000000, 1'b0, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd1000000, 1'b0, 1'b0, 1'b0);
		send(FUNC_EDGE, 32'd1000000, 1'b0, 1'b1, 1'b0);
		send(FUNC_EDGE, 32'd1000001, 1'b1, 1'b1, 1'b0);
		send(FUNC_POLL, 32'd1000001, 1'b1, 1'b0, 1'b0);
		send(FUNC_POLL, 32'd0, 1'b1, 1'b0, 1'b0);
		finish_phase();

		// Random press sequences under a range of thresholds and idling patterns.
		now_us = $urandom();
		run_phase($urandom_range(0, 50), $urandom_range(50, 400), $urandom_range(50, 400),
			$urandom_range(50, 600), 1'b1, 300, 150, 16, 16);
		run_phase($urandom_range(0, 50), $urandom_range(50, 400), $urandom_range(50, 400),
			$urandom_range(50, 600), 1'b0, 300, 150, 0, 0);
		run_phase(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'($urandom_range(0, 1)),
			300, 40, 3, 3);
		now_us = 32'hFFF0_0000;
		run_phase(DEBOUNCE_RST, LONG_RELEASE_RST, LONG_PUSH_RST, IDLE_TIMEOUT_RST,
			ACTIVE_LOW_RST, 3000000, 130, 16, 16);
		run_phase($urandom_range(0, 2000), $urandom_range(0, 20000), $urandom_range(0, 20000),
			$urandom_range(0, 20000), 1'($urandom_range(0, 1)), 20000, 130, 4, 16);

		$display("Checked %0d results for %0d requests, polled and edge, over seven settings.",
			sb.checked, items_sent);
		$display("Events: %0d push, %0d long push, %0d short release, %0d long release, %0d time-out.",
			sb.event_count[1], sb.event_count[2], sb.event_count[3], sb.event_count[4],
			sb.event_count[5]);
		if (sb.mismatches == 0 && sb.expected_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* sim.f */
rtl/pbeq_pkg.sv
rtl/push_button_event_qualifier_core.sv
bench/push_button_event_qualifier_core_test.sv
